[sv/ecsm_pkg.sv]
// Shared types and constants for the elliptic-curve scalar multiplier.
// Used by ecsm_alu and ec_scalar_multiply_mod_n; no dependencies.
package ecsm_pkg;

    localparam int MOD_BITS_DEF    = 32;
    localparam int SCALAR_BITS_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int DATA_W          = 3 * FIELD_W;
    localparam int CFG_IDX_W       = 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MODULUS = 1'b0;
    localparam t_cfg_idx CFG_CURVE_A = 1'b1;

    localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd5;
    localparam logic [FIELD_W-1:0] CURVE_A_RESET = 32'd0;

    // output tuser bit positions
    localparam int USER_INF  = 0;
    localparam int USER_FAIL = 1;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_A,
        S_RED_X,
        S_RED_Y,
        S_LADDER,
        S_PA_CHK,
        S_PA_S,
        S_PA_NUM,
        S_PA_DEN,
        S_PA_XX,
        S_PA_X2,
        S_PA_X3,
        S_PA_XA,
        S_PA_DY,
        S_INV_CHK,
        S_INV_DIV,
        S_INV_QR,
        S_INV_MUL,
        S_INV_SUB,
        S_PA_M,
        S_PA_MM,
        S_PA_X3A,
        S_PA_X3B,
        S_PA_Y1,
        S_PA_Y2,
        S_PA_Y3,
        S_PA_DONE,
        S_FIN
    } t_state;

endpackage

[sv/ecsm_alu.sv]
// Shared modular arithmetic unit: add, subtract, bit-serial multiply, restoring divide.
// Depends on ecsm_pkg.
module ecsm_alu #(
    parameter int DW = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecsm_pkg::t_alu_req i_req,
    input  logic [DW-1:0]     i_a,
    input  logic [DW-1:0]     i_b,
    input  logic [DW-1:0]     i_n,
    output logic              o_done,
    output logic [DW-1:0]     o_res,
    output logic [DW-1:0]     o_rem
);
    import ecsm_pkg::*;

    localparam int CW = $clog2(DW);

    // operands already in [0,n)
    function automatic logic [DW-1:0] madd(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                           input logic [DW-1:0] n);
        logic [DW-1:0] room;
        room = n - b;
        return (a >= room) ? a - room : a + b;
    endfunction

    function automatic logic [DW-1:0] msub(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                           input logic [DW-1:0] n);
        return (a >= b) ? a - b : a + (n - b);
    endfunction

    logic          r_busy;
    logic          r_done;
    t_alu_op       r_op;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_y;
    logic [DW-1:0] r_acc;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;

    logic [DW-1:0] w_dbl;
    logic [DW-1:0] w_mac;
    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW-1:0] w_rem_nx;

    always_comb begin
        w_dbl    = madd(r_acc, r_acc, i_n);
        w_mac    = r_y[DW-1] ? madd(w_dbl, r_x, i_n) : w_dbl;
        w_trial  = {r_rem, r_x[DW-1]};
        w_ge     = (w_trial >= {1'b0, r_y});
        w_rem_nx = w_ge ? DW'(w_trial - {1'b0, r_y}) : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_x    <= i_a;
                r_y    <= i_b;
                r_acc  <= '0;
                r_rem  <= '0;
                r_cnt  <= CW'(DW - 1);
            end else if (r_busy) begin
                case (r_op)
                    ALU_ADD: begin
                        r_acc  <= madd(r_x, r_y, i_n);
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                    ALU_SUB: begin
                        r_acc  <= msub(r_x, r_y, i_n);
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                    ALU_MUL: begin
                        // double-and-add, multiplier bits MSB first
                        r_acc <= w_mac;
                        r_y   <= {r_y[DW-2:0], 1'b0};
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    ALU_DIV: begin
                        // quotient shifts into r_x as the dividend shifts out
                        r_rem <= w_rem_nx;
                        r_x   <= {r_x[DW-2:0], w_ge};
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == ALU_DIV) ? r_x : r_acc;
    assign o_rem  = r_rem;

endmodule

[sv/ec_scalar_multiply_mod_n.sv]
// Elliptic-curve scalar multiplier modulo n: Montgomery ladder sequencer around ecsm_alu.
// Depends on ecsm_pkg and ecsm_alu.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    x, y, scalar (tdata); infinity (tuser)
//  m_axis    out        m_axis_tvalid/m_axis_tready    x, y, factor (tdata); inf, fail (tuser)
//  cfg       in         i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// One item in the core at a time. Multiply and divide run DW iterations between issue
// and done; add and subtract compute in a single step. Each point addition inverts its
// denominator by Euclid steps. An item costs 2*SCALAR_BITS point operations plus three
// reductions.
// Synchronous active-low reset returns to idle; a finished result waits in the output
// register, and s_axis_tready stays low while the next result waits for that register.
module ec_scalar_multiply_mod_n #(
    parameter int MOD_BITS    = ecsm_pkg::MOD_BITS_DEF,
    parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] point_x, [63:32] point_y, [95:64] scalar
    input  logic [ecsm_pkg::DATA_W-1:0] s_axis_tdata,
    // [0] point_is_infinity
    input  logic [0:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [31:0] result_x, [63:32] result_y, [95:64] factor
    output logic [ecsm_pkg::DATA_W-1:0] m_axis_tdata,
    // [0] result_is_infinity, [1] inverse_failed
    output logic [1:0]                  m_axis_tuser,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  ecsm_pkg::t_cfg_idx          i_cfg_index,
    input  logic [ecsm_pkg::FIELD_W-1:0] i_cfg_data
);
    import ecsm_pkg::*;

    localparam int DW = (MOD_BITS > FIELD_W) ? MOD_BITS : FIELD_W;
    localparam int IW = (SCALAR_BITS > 1) ? $clog2(SCALAR_BITS) : 1;
    localparam logic [DW-1:0] MOD_MASK = DW'({MOD_BITS{1'b1}});
    localparam logic [DW-1:0] ONE      = DW'(1);

    t_state r_state, n_state;
    logic   r_issued;
    logic   r_fail;

    logic [FIELD_W-1:0] r_cfg_mod;
    logic [FIELD_W-1:0] r_cfg_a;

    logic [DW-1:0]          r_n, r_a;
    logic [SCALAR_BITS-1:0] r_k;
    logic [IW-1:0]          r_i;
    logic                   r_step;
    logic                   r_binf;

    logic [DW-1:0] r_r0x, r_r0y, r_r1x, r_r1y;
    logic          r_r0inf, r_r1inf;
    logic [DW-1:0] r_px, r_py, r_qx, r_qy;
    logic          r_pinf, r_qinf;
    logic [DW-1:0] r_sx, r_sy;
    logic          r_sinf;
    logic [DW-1:0] r_num, r_den, r_tmp, r_m;
    logic [DW-1:0] r_e0, r_e1, r_e2, r_t0, r_t1, r_q;
    logic [DW-1:0] r_factor;

    logic [FIELD_W-1:0] r_out_x, r_out_y, r_out_f;
    logic               r_out_inf, r_out_fail;
    logic               r_out_valid;

    t_alu_req      w_req;
    logic [DW-1:0] w_alu_a, w_alu_b;
    logic          w_alu_state;
    logic          w_done;
    logic [DW-1:0] w_res, w_rem;
    logic [DW-1:0] w_n_eff;
    logic          w_bit;
    logic          w_dest_r0;
    logic          w_out_free;

    assign w_n_eff   = ((DW'(r_cfg_mod) & MOD_MASK) == '0) ? ONE : (DW'(r_cfg_mod) & MOD_MASK);
    assign w_bit     = r_k[r_i];
    assign w_dest_r0 = w_bit ^ r_step;
    // output register empty, or emptied by a transfer this cycle
    assign w_out_free = !r_out_valid || m_axis_tready;

    ecsm_alu #(.DW(DW)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .i_n     (r_n),
        .o_done  (w_done),
        .o_res   (w_res),
        .o_rem   (w_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (s_axis_tvalid) n_state = S_RED_A;
            S_RED_A:   if (w_done) n_state = S_RED_X;
            S_RED_X:   if (w_done) n_state = S_RED_Y;
            S_RED_Y:   if (w_done) n_state = S_LADDER;
            S_LADDER:  n_state = S_PA_CHK;
            S_PA_CHK:  n_state = (r_pinf || r_qinf) ? S_PA_DONE : S_PA_S;
            S_PA_S: begin
                if (w_done) begin
                    if (r_px == r_qx && w_res == '0) n_state = S_PA_DONE;
                    else if (r_px != r_qx || r_py != r_qy) n_state = S_PA_NUM;
                    else n_state = S_PA_XX;
                end
            end
            S_PA_NUM:  if (w_done) n_state = S_PA_DEN;
            S_PA_DEN:  if (w_done) n_state = S_INV_CHK;
            S_PA_XX:   if (w_done) n_state = S_PA_X2;
            S_PA_X2:   if (w_done) n_state = S_PA_X3;
            S_PA_X3:   if (w_done) n_state = S_PA_XA;
            S_PA_XA:   if (w_done) n_state = S_PA_DY;
            S_PA_DY:   if (w_done) n_state = S_INV_CHK;
            S_INV_CHK: begin
                if (r_e1 != '0) n_state = S_INV_DIV;
                else if (r_e0 != ONE) n_state = S_FIN;
                else n_state = S_PA_M;
            end
            S_INV_DIV: if (w_done) n_state = S_INV_QR;
            S_INV_QR:  if (w_done) n_state = S_INV_MUL;
            S_INV_MUL: if (w_done) n_state = S_INV_SUB;
            S_INV_SUB: if (w_done) n_state = S_INV_CHK;
            S_PA_M:    if (w_done) n_state = S_PA_MM;
            S_PA_MM:   if (w_done) n_state = S_PA_X3A;
            S_PA_X3A:  if (w_done) n_state = S_PA_X3B;
            S_PA_X3B:  if (w_done) n_state = S_PA_Y1;
            S_PA_Y1:   if (w_done) n_state = S_PA_Y2;
            S_PA_Y2:   if (w_done) n_state = S_PA_Y3;
            S_PA_Y3:   if (w_done) n_state = S_PA_DONE;
            S_PA_DONE: n_state = (r_step && r_i == '0) ? S_FIN : S_LADDER;
            S_FIN:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs and ALU operand selection
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = r_out_valid;
        o_cfg_ready   = 1'b1;
        w_alu_state   = 1'b1;
        w_req.op      = ALU_ADD;
        w_alu_a       = r_px;
        w_alu_b       = r_qx;
        case (r_state)
            S_RED_A:   begin w_req.op = ALU_DIV; w_alu_a = DW'(r_cfg_a); w_alu_b = r_n; end
            S_RED_X:   begin w_req.op = ALU_DIV; w_alu_a = r_px;  w_alu_b = r_n;  end
            S_RED_Y:   begin w_req.op = ALU_DIV; w_alu_a = r_py;  w_alu_b = r_n;  end
            S_PA_S:    begin w_req.op = ALU_ADD; w_alu_a = r_py;  w_alu_b = r_qy; end
            S_PA_NUM:  begin w_req.op = ALU_SUB; w_alu_a = r_qy;  w_alu_b = r_py; end
            S_PA_DEN:  begin w_req.op = ALU_SUB; w_alu_a = r_qx;  w_alu_b = r_px; end
            S_PA_XX:   begin w_req.op = ALU_MUL; w_alu_a = r_px;  w_alu_b = r_px; end
            S_PA_X2:   begin w_req.op = ALU_ADD; w_alu_a = r_tmp; w_alu_b = r_tmp; end
            S_PA_X3:   begin w_req.op = ALU_ADD; w_alu_a = r_num; w_alu_b = r_tmp; end
            S_PA_XA:   begin w_req.op = ALU_ADD; w_alu_a = r_num; w_alu_b = r_a;  end
            S_PA_DY:   begin w_req.op = ALU_ADD; w_alu_a = r_py;  w_alu_b = r_py; end
            S_INV_DIV: begin w_req.op = ALU_DIV; w_alu_a = r_e0;  w_alu_b = r_e1; end
            S_INV_QR:  begin w_req.op = ALU_SUB; w_alu_a = r_q;   w_alu_b = r_n;  end
            S_INV_MUL: begin w_req.op = ALU_MUL; w_alu_a = r_q;   w_alu_b = r_t1; end
            S_INV_SUB: begin w_req.op = ALU_SUB; w_alu_a = r_t0;  w_alu_b = r_tmp; end
            S_PA_M:    begin w_req.op = ALU_MUL; w_alu_a = r_num; w_alu_b = r_den; end
            S_PA_MM:   begin w_req.op = ALU_MUL; w_alu_a = r_m;   w_alu_b = r_m;  end
            S_PA_X3A:  begin w_req.op = ALU_SUB; w_alu_a = r_tmp; w_alu_b = r_px; end
            S_PA_X3B:  begin w_req.op = ALU_SUB; w_alu_a = r_tmp; w_alu_b = r_qx; end
            S_PA_Y1:   begin w_req.op = ALU_SUB; w_alu_a = r_px;  w_alu_b = r_num; end
            S_PA_Y2:   begin w_req.op = ALU_MUL; w_alu_a = r_m;   w_alu_b = r_tmp; end
            S_PA_Y3:   begin w_req.op = ALU_SUB; w_alu_a = r_tmp; w_alu_b = r_py; end
            default:   w_alu_state = 1'b0;
        endcase
        w_req.start = w_alu_state && !r_issued;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_mod   <= MODULUS_RESET;
            r_cfg_a     <= CURVE_A_RESET;
        end else begin
            r_state <= n_state;
            if (w_req.start) r_issued <= 1'b1;
            else if (w_done) r_issued <= 1'b0;
            if (r_state == S_FIN && w_out_free) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODULUS: r_cfg_mod <= i_cfg_data;
                    CFG_CURVE_A: r_cfg_a   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_IDLE) r_fail <= 1'b0;
            else if (r_state == S_INV_CHK && r_e1 == '0 && r_e0 != ONE) r_fail <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    r_n    <= w_n_eff;
                    r_px   <= DW'(s_axis_tdata[FIELD_W-1:0]);
                    r_py   <= DW'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
                    r_k    <= SCALAR_BITS'(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
                    r_binf <= s_axis_tuser[0];
                end
            end
            S_RED_A: if (w_done) r_a <= w_rem;
            S_RED_X: if (w_done) r_r1x <= w_rem;
            S_RED_Y: begin
                if (w_done) begin
                    r_r1y   <= r_binf ? '0 : w_rem;
                    r_r1x   <= r_binf ? '0 : r_r1x;
                    r_r1inf <= r_binf;
                    r_r0x   <= '0;
                    r_r0y   <= '0;
                    r_r0inf <= 1'b1;
                    r_i     <= IW'(SCALAR_BITS - 1);
                    r_step  <= 1'b0;
                end
            end
            S_LADDER: begin
                if (!r_step) begin
                    r_px <= r_r0x; r_py <= r_r0y; r_pinf <= r_r0inf;
                    r_qx <= r_r1x; r_qy <= r_r1y; r_qinf <= r_r1inf;
                end else if (w_dest_r0) begin
                    r_px <= r_r0x; r_py <= r_r0y; r_pinf <= r_r0inf;
                    r_qx <= r_r0x; r_qy <= r_r0y; r_qinf <= r_r0inf;
                end else begin
                    r_px <= r_r1x; r_py <= r_r1y; r_pinf <= r_r1inf;
                    r_qx <= r_r1x; r_qy <= r_r1y; r_qinf <= r_r1inf;
                end
            end
            S_PA_CHK: begin
                if (r_pinf) begin
                    r_sx <= r_qx; r_sy <= r_qy; r_sinf <= r_qinf;
                end else begin
                    r_sx <= r_px; r_sy <= r_py; r_sinf <= r_pinf;
                end
            end
            S_PA_S: begin
                r_sx <= '0; r_sy <= '0; r_sinf <= 1'b1;
            end
            S_PA_NUM, S_PA_X2, S_PA_X3, S_PA_XA: if (w_done) r_num <= w_res;
            S_PA_XX, S_PA_MM, S_PA_X3A, S_PA_Y1, S_PA_Y2, S_INV_MUL: begin
                if (w_done) r_tmp <= w_res;
            end
            S_PA_DEN, S_PA_DY: begin
                if (w_done) begin
                    r_den <= w_res;
                    r_e0  <= r_n;
                    r_e1  <= w_res;
                    r_t0  <= '0;
                    r_t1  <= (r_n == ONE) ? '0 : ONE;
                end
            end
            S_INV_CHK: begin
                r_den    <= r_t0;
                r_factor <= r_e0;
            end
            S_INV_DIV: begin
                if (w_done) begin
                    r_q  <= w_res;
                    r_e2 <= w_rem;
                end
            end
            S_INV_QR: if (w_done) r_q <= w_res;
            S_INV_SUB: begin
                if (w_done) begin
                    r_t0 <= r_t1;
                    r_t1 <= w_res;
                    r_e0 <= r_e1;
                    r_e1 <= r_e2;
                end
            end
            S_PA_M:   if (w_done) r_m <= w_res;
            S_PA_X3B: if (w_done) r_num <= w_res;
            S_PA_Y3: begin
                if (w_done) begin
                    r_sx <= r_num; r_sy <= w_res; r_sinf <= 1'b0;
                end
            end
            S_PA_DONE: begin
                if (w_dest_r0) begin
                    r_r0x <= r_sx; r_r0y <= r_sy; r_r0inf <= r_sinf;
                end else begin
                    r_r1x <= r_sx; r_r1y <= r_sy; r_r1inf <= r_sinf;
                end
                r_step <= ~r_step;
                if (r_step) r_i <= r_i - 1'b1;
            end
            S_FIN: begin
                if (w_out_free) begin
                    if (r_fail) begin
                        r_out_x    <= '0;
                        r_out_y    <= '0;
                        r_out_inf  <= 1'b0;
                        r_out_fail <= 1'b1;
                        r_out_f    <= r_factor[FIELD_W-1:0];
                    end else begin
                        r_out_x    <= r_r0inf ? '0 : r_r0x[FIELD_W-1:0];
                        r_out_y    <= r_r0inf ? '0 : r_r0y[FIELD_W-1:0];
                        r_out_inf  <= r_r0inf;
                        r_out_fail <= 1'b0;
                        r_out_f    <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tdata           = {r_out_f, r_out_y, r_out_x};
    assign m_axis_tuser[USER_INF]  = r_out_inf;
    assign m_axis_tuser[USER_FAIL] = r_out_fail;

    // a failure always carries a non-zero factor and zero coordinates
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_FAIL] |->
            m_axis_tdata[95:64] != '0 && m_axis_tdata[63:0] == '0 && !m_axis_tuser[USER_INF])
        else $error("failed result with bad fields");

    a_ok_nofactor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[USER_FAIL] |-> m_axis_tdata[95:64] == '0)
        else $error("factor reported without failure");

    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_INF] |-> m_axis_tdata[63:0] == '0)
        else $error("infinity with non-zero coordinates");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_alu_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |=> !w_req.start)
        else $error("ALU started twice in a row");

endmodule
